// File: hdl/htd_pkg.sv
// shared types, constants and helpers of the huffman tree bit decoder
package htd_pkg;

  // field widths fixed by the item format
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DEPTH     = 2 ** IDX_W;
  localparam int unsigned CNT_W     = $clog2(BYTE_W + 1);
  localparam int unsigned NODES_DEF = 512;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_SYM  = 2'd0,
    STAT_ERR  = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  // one node table entry
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
  } node_t;

  // one result before the last flag is known
  typedef struct packed {
    logic signed [VAL_W-1:0] symbol;
    logic [STAT_W-1:0]       status;
  } res_t;

  // walker to output stage
  typedef struct packed {
    logic push;
    logic close;
    res_t res;
  } ostage_req_t;

  // output stage to walker
  typedef struct packed {
    logic push_ok;
    logic close_ok;
  } ostage_rsp_t;

  // a node with both child indices zero is a leaf
  function automatic logic is_leaf(node_t n);
    return (n.left == '0) && (n.right == '0);
  endfunction

endpackage

// File: hdl/htd_in_if.sv
// input item channel of the huffman tree bit decoder
interface htd_in_if
  import htd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        node_index;
  logic signed [VAL_W-1:0] node_value;
  logic [IDX_W-1:0]        node_left;
  logic [IDX_W-1:0]        node_right;
  logic [BYTE_W-1:0]       data_byte;

  modport source (
    output valid, kind, node_index, node_value, node_left, node_right, data_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, node_index, node_value, node_left, node_right, data_byte,
    output ready
  );
endinterface

// File: hdl/htd_out_if.sv
// result item channel of the huffman tree bit decoder
interface htd_out_if
  import htd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] symbol;
  logic [STAT_W-1:0]       status;
  logic                    last;

  modport source (
    output valid, symbol, status, last,
    input  ready
  );

  modport sink (
    input  valid, symbol, status, last,
    output ready
  );
endinterface

// File: hdl/htd_node_ram.sv
// node table memory, one write port and one registered read port
module htd_node_ram
  import htd_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  node_t            wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output node_t            rdata_o
);

  node_t mem [DEPTH];
  node_t rdata_q;

  // write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/htd_out_stage.sv
// result hold register and output register, sets the last flag at item end
module htd_out_stage
  import htd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ostage_req_t req_i,
  output ostage_rsp_t rsp_o,
  htd_out_if.source   out_o
);

  logic ov_q, ov_d;
  logic hv_q, hv_d;
  res_t hold_q;
  res_t out_res_q;
  logic out_last_q;
  logic out_free;
  logic move;

  // handoff conditions
  assign out_free       = !ov_q || out_o.ready;
  assign rsp_o.push_ok  = !hv_q || out_free;
  assign rsp_o.close_ok = !hv_q || out_free;
  assign move           = (req_i.push || req_i.close) && hv_q && out_free;

  // valid flags of hold and output registers
  always_comb begin
    ov_d = ov_q;
    hv_d = hv_q;
    if (move) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (req_i.push && rsp_o.push_ok) begin
      hv_d = 1'b1;
    end else if (move) begin
      hv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      hv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      hv_q <= hv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.push && rsp_o.push_ok) begin
      hold_q <= req_i.res;
    end
    if (move) begin
      out_res_q  <= hold_q;
      out_last_q <= req_i.close;
    end
  end

  assign out_o.valid  = ov_q;
  assign out_o.symbol = out_res_q.symbol;
  assign out_o.status = out_res_q.status;
  assign out_o.last   = out_last_q;

endmodule

// File: hdl/htd_walk.sv
// tree walk sequencer: item intake, table reads, bit steps and flush walk
module htd_walk
  import htd_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_data_i,
  htd_in_if.sink           in_i,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output node_t            mem_wdata_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  node_t            mem_rdata_i,
  output ostage_req_t      req_o,
  input  ostage_rsp_t      rsp_i
);

  localparam int unsigned STEP_W = $clog2(NODES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DATA,
    S_FLUSH,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic              mid_q, mid_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic [IDX_W-1:0]  root_q;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic              in_fire;
  logic              leaf_a;
  logic [IDX_W-1:0]  child;
  logic [IDX_W-1:0]  start_idx;
  logic [CNT_W-1:0]  cnt_n;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign leaf_a     = is_leaf(mem_rdata_i);
  assign child      = byte_q[BYTE_W-1] ? mem_rdata_i.right : mem_rdata_i.left;
  assign start_idx  = mid_q ? walk_q : root_q;
  assign cnt_n      = st_q ? cnt_q : cnt_q - CNT_W'(1);

  // load items write the table directly
  assign mem_waddr_o       = in_i.node_index;
  assign mem_wdata_o.value = in_i.node_value;
  assign mem_wdata_o.left  = in_i.node_left;
  assign mem_wdata_o.right = in_i.node_right;

  // next state, read address and result requests
  always_comb begin
    state_d     = state_q;
    mid_d       = mid_q;
    walk_d      = walk_q;
    addr_d      = addr_q;
    st_d        = st_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    step_d      = step_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = addr_q;
    req_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.kind)
            KIND_LOAD: begin
              mem_we_o = 1'b1;
            end
            KIND_DATA: begin
              mem_raddr_o = start_idx;
              addr_d      = start_idx;
              st_d        = 1'b0;
              cnt_d       = CNT_W'(BYTE_W);
              byte_d      = in_i.data_byte;
              state_d     = S_DATA;
            end
            KIND_FLUSH: begin
              if (mid_q) begin
                mem_raddr_o = walk_q;
                addr_d      = walk_q;
                step_d      = '0;
                state_d     = S_FLUSH;
              end else begin
                req_o.push       = 1'b1;
                req_o.res.symbol = '0;
                req_o.res.status = STAT_NONE;
                state_d          = S_FIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (leaf_a && (st_q || mid_q)) begin
          // leaf reached by a step, or a stale walk that now ends on a leaf
          req_o.push       = 1'b1;
          req_o.res.symbol = mem_rdata_i.value;
          req_o.res.status = STAT_SYM;
          if (rsp_i.push_ok) begin
            mid_d  = 1'b0;
            walk_d = '0;
            cnt_d  = cnt_n;
            byte_d = st_q ? byte_q : {byte_q[BYTE_W-2:0], 1'b0};
            if (cnt_n == '0) begin
              state_d = S_FIN;
            end else begin
              mem_raddr_o = root_q;
              addr_d      = root_q;
              st_d        = 1'b0;
            end
          end
        end else if (leaf_a) begin
          // walk would start at a leaf root: drop the rest of the byte
          req_o.push       = 1'b1;
          req_o.res.symbol = '0;
          req_o.res.status = STAT_ERR;
          if (rsp_i.push_ok) begin
            state_d = S_FIN;
          end
        end else begin
          // inner node: record it and take the next bit
          if (st_q) begin
            mid_d  = 1'b1;
            walk_d = addr_q;
          end
          if (cnt_q == '0) begin
            state_d = S_FIN;
          end else begin
            mem_raddr_o = child;
            addr_d      = child;
            cnt_d       = cnt_q - CNT_W'(1);
            byte_d      = {byte_q[BYTE_W-2:0], 1'b0};
            st_d        = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (leaf_a || (step_q == STEP_W'(NODES))) begin
          req_o.push       = 1'b1;
          req_o.res.symbol = leaf_a ? mem_rdata_i.value : '0;
          req_o.res.status = leaf_a ? STAT_SYM : STAT_ERR;
          if (rsp_i.push_ok) begin
            mid_d   = 1'b0;
            walk_d  = '0;
            state_d = S_FIN;
          end
        end else begin
          // follow zero bits
          mem_raddr_o = mem_rdata_i.left;
          addr_d      = mem_rdata_i.left;
          step_d      = step_q + STEP_W'(1);
        end
      end
      S_FIN: begin
        req_o.close = 1'b1;
        if (rsp_i.close_ok) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mid_q   <= 1'b0;
      walk_q  <= '0;
      root_q  <= '0;
      st_q    <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      mid_q   <= mid_d;
      walk_q  <= walk_d;
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    byte_q <= byte_d;
  end

endmodule

// File: hdl/huffman_tree_bit_decoder.sv
// Steps: a load item writes the table directly; a data byte takes the first table read,
// the node checks and the handoff to the output stage. A byte that starts at a leaf root
// gives one error result and drops the rest. A flush follows zero-bit steps, up to NODES
// steps, or gives an empty result with no code open. Output stalls hold the walk; else the
// rate is set by the single node table read port, one tree step per cycle.
// Reset (async, active low) clears walk state, root index and channel valids, not the table.
module huffman_tree_bit_decoder
  import htd_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_data_i,
  htd_in_if.sink           in_i,
  htd_out_if.source        out_o
);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  node_t            mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  node_t            mem_rdata;
  ostage_req_t      ostage_req;
  ostage_rsp_t      ostage_rsp;

  // node table
  htd_node_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // walk sequencer
  htd_walk #(
    .NODES (NODES)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .req_o       (ostage_req),
    .rsp_i       (ostage_rsp)
  );

  // result staging
  htd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ostage_req),
    .rsp_o  (ostage_rsp),
    .out_o  (out_o)
  );

endmodule

// File: hdl/htd_checker.sv
// port-level assertions for the huffman tree bit decoder, bound to the top level
module htd_checker
  import htd_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic [KIND_W-1:0]       in_kind_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] out_symbol_i,
  input logic [STAT_W-1:0]       out_status_i,
  input logic                    out_last_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // symbol field is zero unless a symbol was decoded
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STAT_SYM) |-> (out_symbol_i == '0))
    else $error("nonzero symbol on error or empty result");

  // error and nothing-pending results always end their item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_status_i == STAT_ERR) || (out_status_i == STAT_NONE))
      |-> out_last_i)
    else $error("error or empty result without last");

  // a data or flush item keeps the input closed in the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && ((in_kind_i == KIND_DATA) || (in_kind_i == KIND_FLUSH))
      |=> !in_ready_i)
    else $error("input taken while a walk is in progress");

endmodule

bind huffman_tree_bit_decoder htd_checker u_htd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_kind_i    (in_i.kind),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.symbol),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

// File: bench/htd_result_checker.sv
`timescale 1ns / 100ps
// result checker: follows the decoder state from accepted items and compares every result
module htd_result_checker
  import htd_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_data_i,
  htd_in_if                in_mon,
  htd_out_if               out_mon,
  output int unsigned      mismatch_o,
  output int unsigned      pending_o
);

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic signed [VAL_W-1:0] symbol;
    status_e                 status;
    logic                    last;
  } sym_result_t;

  node_t            tree_mem [DEPTH];
  logic [IDX_W-1:0] root_idx;
  logic [IDX_W-1:0] walk_idx;
  logic             in_code;
  sym_result_t      symbols_due_q[$];
  sym_result_t      batch_q[$];
  int unsigned      mismatches;

  // both child indices zero marks a leaf
  function automatic logic is_terminal(input logic [IDX_W-1:0] idx);
    return (tree_mem[idx].left == '0) && (tree_mem[idx].right == '0);
  endfunction

  function automatic void emit(input logic signed [VAL_W-1:0] sym, input status_e st);
    sym_result_t r;
    r.symbol = sym;
    r.status = st;
    r.last   = 1'b0;
    batch_q.push_back(r);
  endfunction

  // one tree step per bit, msb first; the walk carries over to the next byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [IDX_W-1:0] cur;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      cur = in_code ? walk_idx : root_idx;
      if (is_terminal(cur)) begin
        if (!in_code) begin
          // leaf root: one error, rest of the byte dropped
          emit('0, STAT_ERR);
          break;
        end
        // pending node was reloaded as a leaf: this bit only closes the code
        emit(tree_mem[cur].value, STAT_SYM);
        in_code  = 1'b0;
        walk_idx = '0;
      end else begin
        cur = b[i] ? tree_mem[cur].right : tree_mem[cur].left;
        if (is_terminal(cur)) begin
          emit(tree_mem[cur].value, STAT_SYM);
          in_code  = 1'b0;
          walk_idx = '0;
        end else begin
          in_code  = 1'b1;
          walk_idx = cur;
        end
      end
    end
  endtask

  // end of stream: follow left children a bounded number of steps
  task automatic flush_walk();
    logic [IDX_W-1:0] cur;
    int unsigned      steps;
    if (!in_code) begin
      emit('0, STAT_NONE);
    end else begin
      cur   = walk_idx;
      steps = 0;
      while (!is_terminal(cur) && steps < NODES) begin
        cur = tree_mem[cur].left;
        steps++;
      end
      if (is_terminal(cur)) emit(tree_mem[cur].value, STAT_SYM);
      else emit('0, STAT_ERR);
    end
    in_code  = 1'b0;
    walk_idx = '0;
  endtask

  task automatic check_result();
    sym_result_t want;
    if (symbols_due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t unexpected result: symbol %0d status %0d last %0b",
                 $time, out_mon.symbol, out_mon.status, out_mon.last);
    end else begin
      want = symbols_due_q.pop_front();
      if (out_mon.symbol !== want.symbol || out_mon.status !== want.status ||
          out_mon.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t result wrong: expected symbol %0d status %0d last %0b, got symbol %0d status %0d last %0b",
                   $time, want.symbol, want.status, want.last,
                   out_mon.symbol, out_mon.status, out_mon.last);
      end
    end
  endtask

  // track state on accepted items, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_idx   = '0;
      walk_idx   = '0;
      in_code    = 1'b0;
      mismatches = 0;
      symbols_due_q.delete();
      mismatch_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) root_idx = cfg_data_i;
      if (in_mon.valid && in_mon.ready) begin
        batch_q.delete();
        case (in_mon.kind)
          KIND_LOAD:  tree_mem[in_mon.node_index] =
                        {in_mon.node_value, in_mon.node_left, in_mon.node_right};
          KIND_DATA:  decode_byte(in_mon.data_byte);
          KIND_FLUSH: flush_walk();
          default: ;
        endcase
        if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
        foreach (batch_q[k]) symbols_due_q.push_back(batch_q[k]);
      end
      if (out_mon.valid && out_mon.ready) check_result();
      mismatch_o <= mismatches;
      pending_o  <= symbols_due_q.size();
    end
  end

endmodule

// File: bench/huffman_tree_bit_decoder_test.sv
`timescale 1ns / 100ps
// top of the decoder test: clock, reset, tree loads, byte stream, flow control and verdict
module huffman_tree_bit_decoder_test;
  import htd_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE         = 40;
  localparam int unsigned PHASES         = 11;
  localparam int unsigned PHASE_ITEMS    = 22;
  localparam int unsigned PRESSURE_PHASE = 3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_data_i;
  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      hold_ask;
  int unsigned      hold_taken;
  int unsigned      hold_left;
  int unsigned      stall_left;
  int unsigned      rx_mode_left;
  bit               rx_quiet;
  bit               tx_quiet;
  bit               written [DEPTH];
  logic [IDX_W-1:0] known_q[$];
  logic [IDX_W-1:0] phase_q[$];

  htd_in_if  in_ch();
  htd_out_if out_ch();

  huffman_tree_bit_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  htd_result_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // idle lengths: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // children always point at loaded entries, mostly this phase's nodes so codes get deep
  function automatic logic [IDX_W-1:0] pick_known();
    if (phase_q.size() > 0 && $urandom_range(0, 3) != 0)
      return phase_q[$urandom_range(0, phase_q.size() - 1)];
    return known_q[$urandom_range(0, known_q.size() - 1)];
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val,
                           input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt,
                           input logic [BYTE_W-1:0] data);
    int unsigned gap;
    gap = (tx_quiet || $urandom_range(0, 9) < 6) ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.node_index <= idx;
    in_ch.node_value <= val;
    in_ch.node_left  <= lft;
    in_ch.node_right <= rgt;
    in_ch.data_byte  <= data;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val,
                           input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt);
    send_item(KIND_LOAD, idx, val, lft, rgt, BYTE_W'($urandom()));
    if (!written[idx]) begin
      written[idx] = 1'b1;
      known_q.push_back(idx);
    end
    phase_q.push_back(idx);
  endtask

  task automatic data_item(input logic [BYTE_W-1:0] b);
    send_item(KIND_DATA, IDX_W'($urandom()), VAL_W'($urandom()), IDX_W'($urandom()),
              IDX_W'($urandom()), b);
  endtask

  task automatic flush_item();
    send_item(KIND_FLUSH, IDX_W'($urandom()), VAL_W'($urandom()), IDX_W'($urandom()),
              IDX_W'($urandom()), BYTE_W'($urandom()));
  endtask

  task automatic spare_item();
    send_item(KIND_SPARE, IDX_W'($urandom()), VAL_W'($urandom()), IDX_W'($urandom()),
              IDX_W'($urandom()), BYTE_W'($urandom()));
  endtask

  // wait until every expected result is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] idx);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= idx;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // leaves first, then inner nodes over already loaded entries
  task automatic grow_tree(input int unsigned leaves, input int unsigned inner);
    logic [IDX_W-1:0] lft;
    logic [IDX_W-1:0] rgt;
    phase_q.delete();
    repeat (leaves) load_node(IDX_W'($urandom_range(0, DEPTH - 1)), pick_value(), '0, '0);
    repeat (inner) begin
      lft = pick_known();
      rgt = pick_known();
      load_node(IDX_W'($urandom_range(0, DEPTH - 1)), pick_value(), lft, rgt);
    end
  endtask

  // result side: random stalls, quiet stretches and one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    hold_taken   = 0;
    hold_left    = 0;
    stall_left   = 0;
    rx_mode_left = 0;
    rx_quiet     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_taken) begin
        hold_taken = hold_ask;
        hold_left  = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(50, 300);
        rx_quiet     = ($urandom_range(0, 3) == 0);
      end
      rx_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = gap_len();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // item side
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.node_index = '0;
    in_ch.node_value = '0;
    in_ch.node_left  = '0;
    in_ch.node_right = '0;
    in_ch.data_byte  = '0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    hold_ask         = 0;
    tx_quiet         = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // root at reset index and a leaf: error per byte
    load_node('0, 16'sh8000, '0, '0);
    data_item(8'ha5);
    // small tree: 0 -> node 0, 10 -> node 511, 11 -> node 256
    load_node(IDX_W'(DEPTH - 1), 16'sh7fff, '0, '0);
    load_node(IDX_W'(256), -16'sd1, '0, '0);
    load_node(IDX_W'(85), 16'sd5, IDX_W'(DEPTH - 1), IDX_W'(256));
    load_node(IDX_W'(170), 16'sd7, '0, IDX_W'(85));
    drain();
    write_root(IDX_W'(170));
    data_item(8'h00);
    data_item(8'hff);
    // code left open across the byte, closed by flush
    data_item(8'h01);
    flush_item();
    flush_item();
    // pending node reloaded as a leaf, closed by the next data bit
    data_item(8'h01);
    load_node(IDX_W'(85), 16'sh1234, '0, '0);
    data_item(8'h80);
    load_node(IDX_W'(85), 16'sd5, IDX_W'(DEPTH - 1), IDX_W'(256));
    // same, closed by a flush
    data_item(8'h01);
    load_node(IDX_W'(85), 16'sh1234, '0, '0);
    flush_item();
    load_node(IDX_W'(85), 16'sd5, IDX_W'(DEPTH - 1), IDX_W'(256));
    data_item(8'haa);
    // self loop on the left: data walks without result, flush gives up
    load_node(IDX_W'(300), 16'sd9, IDX_W'(300), IDX_W'(256));
    load_node(IDX_W'(170), 16'sd7, '0, IDX_W'(300));
    data_item(8'h80);
    flush_item();
    spare_item();
    data_item(8'h5f);
    flush_item();
    drain();

    // random phases: fresh tree, new root, byte stream with reloads and flushes
    for (int p = 0; p < PHASES; p++) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      grow_tree($urandom_range(2, 5), $urandom_range(3, 9));
      drain();
      if (p == 0) write_root(IDX_W'(DEPTH - 1));
      else if (p == 1) write_root('0);
      else write_root(phase_q[phase_q.size() - 1]);
      if (p == PRESSURE_PHASE) begin
        hold_ask <= hold_ask + 1;
        tx_quiet = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0, 1:    flush_item();
          2:       load_node(pick_known(), pick_value(), '0, '0);
          3:       load_node($urandom_range(0, 1) ? pick_known()
                                                  : IDX_W'($urandom_range(0, DEPTH - 1)),
                             pick_value(), pick_known(), pick_known());
          4:       spare_item();
          default: data_item(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
      flush_item();
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
